// File: rtl/core/qerm_pkg.sv
package qerm_pkg;

    // Input item kinds.
    localparam logic [1:0] KIND_EDGE = 2'd0;
    localparam logic [1:0] KIND_TIME = 2'd1;
    localparam logic [1:0] KIND_ZERO = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PPR    = 1'd1;

    // Configuration reset values.
    localparam logic [15:0] PERIOD_RESET = 16'd500;
    localparam logic [15:0] PPR_RESET    = 16'd960;

    // Edges per minute scale factor, milliseconds per minute.
    localparam logic [15:0] RPM_FACTOR = 16'd60000;

    // Elapsed time counter and its ceiling.
    localparam int unsigned ELAPSED_W = 17;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'h1FFFF;

    // Divisor is pulses per revolution times elapsed milliseconds.
    localparam int unsigned DEN_W = 33;

    // The quotient is developed one bit per cycle, 32 bits in all.
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned STEP_W    = 6;

    // Saturation limits of the speed result.
    localparam logic [31:0] RPM_POS_LIM = 32'h7FFF_FFFF;
    localparam logic [31:0] RPM_NEG_LIM = 32'h8000_0000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the accepted input item
        logic exec;      // apply the item to the counters
        logic absv;      // take sign and magnitude of the delta
        logic mul;       // one 16-bit partial product of the scaling
        logic chk;       // divisor and overflow check, remainder setup
        logic div;       // one quotient bit
        logic sat;       // clamp and apply sign
        logic out_load;  // load the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic meas;      // current time advance item completes a measurement
        logic skip_div;  // divisor zero or quotient certain to saturate
    } t_dp_sts;

endpackage

// File: rtl/core/quadrature_encoder_rpm_meter_top.sv
// Quadrature encoder position counter and speed meter.
// Input channel (i_valid/o_ready) carries one item per transfer: a phase A
// rising edge with the phase B level, a time advance of i_tick_ms
// milliseconds, or a command that zeroes the position and speed state.
// Every item yields exactly one result on the output channel (o_valid/i_ready)
// with the position, the last period's delta, the speed in rpm and a flag
// that marks a completed measurement.
// With C the count width in 16-bit chunks, rounded up (2 by default), an item
// that takes no measurement passes through the exec and output states only; a
// measurement adds the sign and magnitude step, the scaling (one partial
// product per cycle, C in all), the divisor check, a restoring divide and the
// clamp, while a zero divisor or a certain overflow skips the divide and clamp.
// Items are processed one at a time; o_ready rises at the edge that loads the
// result.
// The output register holds one result; while the receiver stalls the next
// item may be accepted and worked on, but it waits before loading its result.
// Synchronous reset clears all counters, loads the period with 500 ms and
// the pulses per revolution with 960, and empties the output register.
// Configuration writes take effect at once and are meant for idle periods.
module quadrature_encoder_rpm_meter_top
    import qerm_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_wdata,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_kind,
    input  logic                 i_phase_b,
    input  logic [7:0]           i_tick_ms,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [31:0]   o_position_count,
    output logic signed [31:0]   o_last_delta,
    output logic signed [31:0]   o_speed_rpm,
    output logic                 o_sample_done
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer.
    qerm_ctrl #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Counters, scaling multiply, divider and output register.
    qerm_dp #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_kind           (i_kind),
        .i_phase_b        (i_phase_b),
        .i_tick_ms        (i_tick_ms),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_position_count (o_position_count),
        .o_last_delta     (o_last_delta),
        .o_speed_rpm      (o_speed_rpm),
        .o_sample_done    (o_sample_done)
    );

    // An accepted item keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready
    ) else $error("input accepted while an item was still in progress");

    // Loading a result makes it visible and frees the input side.
    a_load_shows_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> (o_valid && o_ready)
    ) else $error("result load did not present a result and return to idle");

    // A new result appears only through a load of the output register.
    a_valid_from_load: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.out_load)
    ) else $error("output valid rose without a result load");

endmodule

// File: rtl/core/qerm_dp.sv
module qerm_dp
    import qerm_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [15:0]                 i_cfg_wdata,
    input  logic [1:0]                  i_kind,
    input  logic                        i_phase_b,
    input  logic [7:0]                  i_tick_ms,
    input  t_dp_cmd                     i_cmd,
    output t_dp_sts                     o_sts,
    output logic signed [31:0]          o_position_count,
    output logic signed [31:0]          o_last_delta,
    output logic signed [31:0]          o_speed_rpm,
    output logic                        o_sample_done
);

    localparam int unsigned CW     = COUNT_WIDTH;
    // Magnitude padded to whole 16-bit chunks for the serial multiply.
    localparam int unsigned MAG_W  = ((CW + 15) / 16) * 16;
    // Product needs MAG_W+16 bits; the extra padding keeps the part above
    // the 32 quotient bits at least as wide as the divisor.
    localparam int unsigned PROD_W = MAG_W + 49;
    localparam int unsigned HI_W   = PROD_W - 32;

    // Configuration registers.
    logic [15:0]          r_period;
    logic [15:0]          r_ppr;

    // Captured input item.
    logic [1:0]           r_kind;
    logic                 r_phase_b;
    logic [7:0]           r_tick;

    // Measurement state.
    logic [CW-1:0]        r_pos;
    logic [CW-1:0]        r_prev;
    logic [CW-1:0]        r_delta;
    logic [31:0]          r_speed;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic                 r_done;

    // Arithmetic working registers.
    logic [DEN_W-1:0]     r_den;
    logic                 r_neg;
    logic [MAG_W-1:0]     r_mag;
    logic [PROD_W-1:0]    r_prod;
    logic [DEN_W-1:0]     r_rem;
    logic [31:0]          r_quo;

    // Output register.
    logic [31:0]          r_out_pos;
    logic [31:0]          r_out_delta;
    logic [31:0]          r_out_speed;
    logic                 r_out_done;

    logic [ELAPSED_W:0]   w_esum;
    logic [ELAPSED_W-1:0] w_esat;
    logic                 w_meas;
    logic [CW-1:0]        w_abs;
    logic [31:0]          w_part;
    logic [HI_W-1:0]      w_hi;
    logic                 w_den_zero;
    logic                 w_ovf;
    logic [DEN_W:0]       w_trial;
    logic [31:0]          w_lim;
    logic [31:0]          w_qsat;
    logic [31:0]          w_pos32;
    logic [31:0]          w_delta32;

    // Elapsed time after a time advance, held at its ceiling.
    assign w_esum = {1'b0, r_elapsed} + {{(ELAPSED_W - 7){1'b0}}, r_tick};
    assign w_esat = w_esum[ELAPSED_W] ? ELAPSED_MAX : w_esum[ELAPSED_W-1:0];
    assign w_meas = (r_kind == KIND_TIME) && (w_esat >= {1'b0, r_period});

    // Magnitude of the signed delta; the most negative value maps correctly
    // because the magnitude is read unsigned.
    assign w_abs = r_delta[CW-1] ? (~r_delta + CW'(1)) : r_delta;

    // One partial product of the magnitude and the scale factor.
    assign w_part = {16'b0, r_mag[MAG_W-1 -: 16]} * {16'b0, RPM_FACTOR};

    // A quotient of 2^32 or more always saturates.
    assign w_hi       = r_prod[PROD_W-1:32];
    assign w_den_zero = (r_den == '0);
    assign w_ovf      = (w_hi >= HI_W'(r_den));

    // Restoring division trial subtract.
    assign w_trial = {r_rem, r_quo[31]} - {1'b0, r_den};

    // Clamp against the limit of the result sign.
    assign w_lim  = r_neg ? RPM_NEG_LIM : RPM_POS_LIM;
    assign w_qsat = (r_quo > w_lim) ? w_lim : r_quo;

    assign o_sts.meas     = w_meas;
    assign o_sts.skip_div = w_den_zero || w_ovf;

    // Low 32 bits of the sign-extended counters.
    generate
        if (CW >= 32) begin : g_wide
            assign w_pos32   = r_pos[31:0];
            assign w_delta32 = r_delta[31:0];
        end else begin : g_narrow
            assign w_pos32   = {{(32 - CW){r_pos[CW-1]}}, r_pos};
            assign w_delta32 = {{(32 - CW){r_delta[CW-1]}}, r_delta};
        end
    endgenerate

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_ppr    <= PPR_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_PERIOD) begin
                r_period <= i_cfg_wdata;
            end else if (i_cfg_idx == CFG_PPR) begin
                r_ppr <= i_cfg_wdata;
            end
        end
    end

    // Input item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_kind;
            r_phase_b <= i_phase_b;
            r_tick    <= i_tick_ms;
        end
    end

    // Counters and measurement state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_prev    <= '0;
            r_delta   <= '0;
            r_speed   <= '0;
            r_elapsed <= '0;
            r_done    <= 1'b0;
        end else if (i_cmd.exec) begin
            r_done <= w_meas;
            unique case (r_kind)
                KIND_EDGE: begin
                    r_pos <= r_phase_b ? (r_pos - CW'(1)) : (r_pos + CW'(1));
                end
                KIND_TIME: begin
                    if (w_meas) begin
                        r_delta   <= r_pos - r_prev;
                        r_prev    <= r_pos;
                        r_elapsed <= '0;
                    end else begin
                        r_elapsed <= w_esat;
                    end
                end
                KIND_ZERO: begin
                    r_pos   <= '0;
                    r_prev  <= '0;
                    r_delta <= '0;
                    r_speed <= '0;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.chk) begin
            if (w_den_zero) begin
                r_speed <= '0;
            end else if (w_ovf) begin
                r_speed <= w_lim;
            end
        end else if (i_cmd.sat) begin
            r_speed <= r_neg ? (~w_qsat + 32'd1) : w_qsat;
        end
    end

    // Divisor, taken with the elapsed time that triggered the measurement.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_den <= {17'b0, r_ppr} * {16'b0, w_esat};
        end
    end

    // Sign, magnitude and serial multiply, most significant chunk first.
    always_ff @(posedge i_clk) begin
        if (i_cmd.absv) begin
            r_neg  <= r_delta[CW-1];
            r_mag  <= MAG_W'(w_abs);
            r_prod <= '0;
        end else if (i_cmd.mul) begin
            r_mag  <= r_mag << 16;
            r_prod <= (r_prod << 16) + PROD_W'(w_part);
        end
    end

    // Long division of the scaled magnitude, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.chk) begin
            r_rem <= r_prod[32 +: DEN_W];
            r_quo <= r_prod[31:0];
        end else if (i_cmd.div) begin
            if (!w_trial[DEN_W]) begin
                r_rem <= w_trial[DEN_W-1:0];
            end else begin
                r_rem <= {r_rem[DEN_W-2:0], r_quo[31]};
            end
            r_quo <= {r_quo[30:0], ~w_trial[DEN_W]};
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_pos   <= w_pos32;
            r_out_delta <= w_delta32;
            r_out_speed <= r_speed;
            r_out_done  <= r_done;
        end
    end

    assign o_position_count = r_out_pos;
    assign o_last_delta     = r_out_delta;
    assign o_speed_rpm      = r_out_speed;
    assign o_sample_done    = r_out_done;

endmodule

// File: rtl/core/qerm_ctrl.sv
module qerm_ctrl
    import qerm_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    // Number of 16-bit chunks of the delta magnitude.
    localparam int unsigned MUL_STEPS = (COUNT_WIDTH + 15) / 16;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_ABS  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_CHK  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_SAT  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              w_slot_free;

    assign w_slot_free = !r_out_valid || i_ready;

    // Sequencing of one item through the datapath.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.meas ? ST_ABS : ST_OUT;
            end
            ST_ABS: begin
                o_cmd.absv = 1'b1;
                n_step     = '0;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = ST_CHK;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_CHK: begin
                o_cmd.chk = 1'b1;
                n_step    = '0;
                n_state   = i_sts.skip_div ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = ST_SAT;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_SAT: begin
                o_cmd.sat = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register occupancy.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import qerm_pkg::*;

    localparam int CNT_W = 32;
    // Kind code that the block does not define; it must leave all state alone.
    localparam logic [1:0] KIND_SPARE = 2'd3;
    // Cycles allowed after the last result before the block counts as idle.
    localparam int SETTLE_CYCLES = 45;
    localparam int CYCLE_LIMIT = 4_000_000;
    // Edges sent in each direction within one millisecond for the fast test.
    localparam int FAST_EDGES = 60;
    localparam longint RPM_MAX = 64'sd2147483647;
    localparam longint RPM_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] position;
        logic signed [31:0] delta;
        logic signed [31:0] rpm;
        logic done;
    } t_reading;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [1:0] i_kind = '0;
    logic i_phase_b = 1'b0;
    logic [7:0] i_tick_ms = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [31:0] o_position_count;
    logic signed [31:0] o_last_delta;
    logic signed [31:0] o_speed_rpm;
    logic o_sample_done;

    // Shadow copy of the meter's registers and counters.
    logic [15:0] cfg_period = PERIOD_RESET;
    logic [15:0] cfg_ppr = PPR_RESET;
    logic [CNT_W-1:0] enc_position = '0;
    logic [CNT_W-1:0] enc_prev_position = '0;
    logic [CNT_W-1:0] enc_delta = '0;
    logic [31:0] enc_speed = '0;
    logic [ELAPSED_W-1:0] enc_elapsed = '0;

    t_reading expected_readings[$];
    int send_gap_pct = 0;
    int ready_stall_pct = 0;
    int mismatch_count = 0;
    int items_sent = 0;
    int measurements_seen = 0;
    int cycle_count = 0;

    quadrature_encoder_rpm_meter_top #(
        .COUNT_WIDTH(CNT_W)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_kind(i_kind),
        .i_phase_b(i_phase_b),
        .i_tick_ms(i_tick_ms),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_position_count(o_position_count),
        .o_last_delta(o_last_delta),
        .o_speed_rpm(o_speed_rpm),
        .o_sample_done(o_sample_done)
    );

    always #6 i_clk = ~i_clk;

    // Scaled speed: delta*60000/den, truncated toward zero and clamped to 32 bits.
    function automatic logic [31:0] speed_from_delta(input logic signed [31:0] delta,
                                                    input logic [32:0] den);
        longint num;
        longint quo;
        if (den == '0) begin
            return '0;
        end
        num = longint'(delta) * longint'(RPM_FACTOR);
        quo = num / longint'(den);
        if (quo > RPM_MAX) begin
            quo = RPM_MAX;
        end else if (quo < RPM_MIN) begin
            quo = RPM_MIN;
        end
        return quo[31:0];
    endfunction

    // Apply one item to the shadow state and return the reading it should produce.
    task automatic predict_reading(input logic [1:0] kind, input logic pb,
                                   input logic [7:0] tick, output t_reading r);
        logic [ELAPSED_W:0] sum;
        logic [32:0] den;
        r.done = 1'b0;
        case (kind)
            KIND_EDGE: begin
                enc_position = pb ? enc_position - CNT_W'(1) : enc_position + CNT_W'(1);
            end
            KIND_TIME: begin
                sum = {1'b0, enc_elapsed} + (ELAPSED_W + 1)'(tick);
                enc_elapsed = sum[ELAPSED_W] ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
                if (enc_elapsed >= {1'b0, cfg_period}) begin
                    den = 33'(cfg_ppr) * 33'(enc_elapsed);
                    enc_delta = enc_position - enc_prev_position;
                    enc_speed = speed_from_delta(enc_delta, den);
                    enc_prev_position = enc_position;
                    enc_elapsed = '0;
                    r.done = 1'b1;
                end
            end
            KIND_ZERO: begin
                enc_position = '0;
                enc_prev_position = '0;
                enc_delta = '0;
                enc_speed = '0;
            end
            default: begin
            end
        endcase
        r.position = enc_position;
        r.delta = enc_delta;
        r.rpm = enc_speed;
    endtask

    // Present one item, hold it until the transfer, then queue its reading.
    task automatic send_item(input logic [1:0] kind, input logic pb, input logic [7:0] tick);
        t_reading want;
        if ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_phase_b <= pb;
        i_tick_ms <= tick;
        do @(posedge i_clk); while (!o_ready);
        predict_reading(kind, pb, tick, want);
        expected_readings.push_back(want);
        items_sent++;
    endtask

    // Stop sending and let every pending reading come back.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_PERIOD) begin
            cfg_period = value;
        end else if (idx == CFG_PPR) begin
            cfg_ppr = value;
        end
    endtask

    // Registers change only once the meter has gone quiet.
    task automatic apply_setting(input logic [15:0] period, input logic [15:0] ppr);
        wait_for_results();
        write_reg(CFG_PERIOD, period);
        write_reg(CFG_PPR, ppr);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver: random back-pressure, and each transfer is checked in order.
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_readings.size() == 0) begin
                    $error("reading transferred with no item pending");
                    mismatch_count++;
                end else begin
                    want = expected_readings.pop_front();
                    check_field("position_count", want.position, o_position_count);
                    check_field("last_delta", want.delta, o_last_delta);
                    check_field("speed_rpm", want.rpm, o_speed_rpm);
                    check_field("sample_done", 32'(want.done), 32'(o_sample_done));
                    if (o_sample_done) begin
                        measurements_seen++;
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d readings pending",
                     cycle_count, expected_readings.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Counting both ways, the unused kind, tick zero and a measurement at reset values.
    task automatic test_reset_defaults();
        apply_setting(PERIOD_RESET, PPR_RESET);
        send_item(KIND_SPARE, 1'b1, 8'd255);
        send_item(KIND_EDGE, 1'b0, 8'd0);
        send_item(KIND_EDGE, 1'b0, 8'd255);
        send_item(KIND_EDGE, 1'b0, 8'd17);
        send_item(KIND_EDGE, 1'b1, 8'd0);
        send_item(KIND_TIME, 1'b1, 8'd0);
        send_item(KIND_TIME, 1'b0, 8'd255);
        send_item(KIND_TIME, 1'b1, 8'd255);
        send_item(KIND_ZERO, 1'b1, 8'd255);
        send_item(KIND_EDGE, 1'b1, 8'd3);
        send_item(KIND_SPARE, 1'b0, 8'd0);
    endtask

    // Zero divisor, a zero period, and elapsed time kept across a zero item.
    task automatic test_divisor_and_period();
        apply_setting(16'd1, 16'd0);
        send_item(KIND_EDGE, 1'b0, 8'd0);
        send_item(KIND_TIME, 1'b0, 8'd1);
        apply_setting(16'd0, 16'd1);
        send_item(KIND_TIME, 1'b0, 8'd0);
        send_item(KIND_EDGE, 1'b1, 8'd0);
        send_item(KIND_TIME, 1'b0, 8'd7);
        apply_setting(16'd300, 16'd1);
        send_item(KIND_TIME, 1'b0, 8'd200);
        send_item(KIND_ZERO, 1'b0, 8'd0);
        send_item(KIND_EDGE, 1'b0, 8'd0);
        send_item(KIND_EDGE, 1'b0, 8'd0);
        send_item(KIND_TIME, 1'b0, 8'd100);
        // Build up elapsed time, then shorten the period: only the next tick measures.
        apply_setting(16'hFFFF, 16'hFFFF);
        send_item(KIND_TIME, 1'b0, 8'd255);
        send_item(KIND_TIME, 1'b1, 8'd255);
        apply_setting(16'd1, 16'd3);
        send_item(KIND_TIME, 1'b0, 8'd0);
    endtask

    // Many edges within one millisecond and a divisor of one give large speeds of both signs.
    task automatic test_high_speed();
        send_gap_pct = 0;
        ready_stall_pct = 0;
        apply_setting(16'd1, 16'd1);
        send_item(KIND_TIME, 1'b0, 8'd1);
        repeat (FAST_EDGES) send_item(KIND_EDGE, 1'b0, 8'($urandom_range(255)));
        send_item(KIND_TIME, 1'b0, 8'd1);
        repeat (FAST_EDGES) send_item(KIND_EDGE, 1'b1, 8'($urandom_range(255)));
        send_item(KIND_TIME, 1'b1, 8'd1);
    endtask

    // Mostly edges and ticks with a per-phase direction bias, plus zeros and noise.
    task automatic run_random_phase(input int count);
        int counted;
        int pick;
        int down_pct;
        logic [1:0] kind;
        counted = 0;
        down_pct = $urandom_range(100);
        while (counted < count) begin
            pick = $urandom_range(99);
            if (pick < 58) begin
                kind = KIND_EDGE;
            end else if (pick < 88) begin
                kind = KIND_TIME;
            end else if (pick < 94) begin
                kind = KIND_ZERO;
            end else begin
                kind = KIND_SPARE;
            end
            send_item(kind, $urandom_range(99) < down_pct, 8'($urandom_range(255)));
            if (kind != KIND_SPARE) begin
                counted++;
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [15:0] period;
        logic [15:0] ppr;
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_gap_pct = 6;
                    ready_stall_pct = 60;
                end
                1: begin
                    send_gap_pct = 60;
                    ready_stall_pct = 6;
                end
                default: begin
                    send_gap_pct = 0;
                    ready_stall_pct = 0;
                end
            endcase
            for (int part = 0; part < 2; part++) begin
                case (mode * 2 + part)
                    0: begin
                        period = 16'($urandom_range(1, 400));
                        ppr = 16'($urandom_range(0, 3000));
                    end
                    1: begin
                        period = 16'hFFFF;
                        ppr = 16'hFFFF;
                    end
                    2: begin
                        period = 16'd0;
                        ppr = 16'($urandom_range(1, 2000));
                    end
                    3: begin
                        period = 16'd1;
                        ppr = 16'd1;
                    end
                    4: begin
                        period = 16'($urandom);
                        ppr = 16'($urandom);
                    end
                    default: begin
                        period = 16'($urandom_range(1, 400));
                        ppr = PPR_RESET;
                    end
                endcase
                apply_setting(period, ppr);
                run_random_phase(90);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_divisor_and_period();
        test_high_speed();
        test_random_traffic();
        wait_for_results();

        if (expected_readings.size() != 0) begin
            $error("%0d readings never arrived", expected_readings.size());
            mismatch_count += expected_readings.size();
        end
        $display("Sent %0d items over %0d cycles; %0d readings completed a measurement.",
                 items_sent, cycle_count, measurements_seen);
        $display("Covered zero divisor, zero period, 16-bit register extremes and fast motion.");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/qerm_pkg.sv
rtl/core/qerm_dp.sv
rtl/core/qerm_ctrl.sv
rtl/core/quadrature_encoder_rpm_meter_top.sv
bench/tb.sv
